/* hw/rtl/pssd_pkg.sv */
// ----------------------------------------------------------------------------
// pssd_pkg
// Shared types and constants for the positional symbol-set distance unit.
// ----------------------------------------------------------------------------
package pssd_pkg;

	// Symbol alphabet and widths of the fixed fields
	localparam int unsigned SYMBOL_COUNT = 256;
	localparam int unsigned SYMBOL_W     = 8;
	localparam int unsigned LEN_W        = 7;
	localparam int unsigned DIST_W       = 7;

	// One profile row: seen set in the low bits, base byte on top
	localparam int unsigned ROW_W        = SYMBOL_COUNT + SYMBOL_W;

	// Reset value of the length register and ceiling of the distance count
	localparam logic [LEN_W-1:0]  LEN_RESET = 7'd64;
	localparam logic [DIST_W-1:0] DIST_MAX  = 7'd127;

	// Operation codes carried on the input's user bit
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic clear_step;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic need_out;
		logic out_blocked;
	} ctrl_sts_t;

endpackage

/* hw/rtl/pssd_ram.sv */
// ----------------------------------------------------------------------------
// pssd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pssd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/pssd_ctrl.sv */
// ----------------------------------------------------------------------------
// pssd_ctrl
// Controller: clearing sweep after reset, then for each accepted byte a read
// on acceptance and an update in ST_EXEC, held while a query result waits.
// ----------------------------------------------------------------------------
module pssd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  pssd_pkg::ctrl_sts_t sts,
	output pssd_pkg::ctrl_cmd_t cmd
);

	import pssd_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!(sts.need_out && sts.out_blocked)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready       = 1'b0;
		cmd.accept     = 1'b0;
		cmd.exec       = 1'b0;
		cmd.clear_step = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_EXEC: begin
				// A result waits for room in the output register
				cmd.exec = !(sts.need_out && sts.out_blocked);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* hw/rtl/pssd_dp.sv */
// ----------------------------------------------------------------------------
// pssd_dp
// Datapath: profile memory, position and mismatch counters, length register
// and the output register.
// ----------------------------------------------------------------------------
module pssd_dp #(
	parameter int unsigned MAX_LENGTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pssd_pkg::ctrl_cmd_t           cmd,
	output pssd_pkg::ctrl_sts_t           sts,
	input  logic [pssd_pkg::SYMBOL_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic                          cfg_valid,
	input  logic [pssd_pkg::LEN_W-1:0]    cfg_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata
);

	import pssd_pkg::*;

	localparam int unsigned AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int unsigned PW = $clog2(MAX_LENGTH + 1);
	localparam int unsigned CW = (PW > LEN_W) ? PW : LEN_W;

	logic [LEN_W-1:0]    string_length_q;
	logic [PW-1:0]       pos_q;
	logic [DIST_W-1:0]   cnt_q;
	logic                started_q;
	logic [AW-1:0]       clr_q;
	logic                op_q;
	logic [SYMBOL_W-1:0] sym_q;
	logic                last_q;
	logic                m_tvalid_q;
	logic [DIST_W-1:0]   dist_q;

	logic [ROW_W-1:0]    row_rd;
	logic [ROW_W-1:0]    row_wr;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ROW_W-1:0]    ram_wdata;
	logic                in_range;
	logic                known;
	logic                not_sat;
	logic [DIST_W-1:0]   cnt_next;

	// Length register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_length_q <= LEN_RESET;
		end else if (cfg_valid) begin
			string_length_q <= cfg_data;
		end
	end

	// Captured input byte
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= s_tuser;
			sym_q  <= s_tdata;
			last_q <= s_tlast;
		end
	end

	// Position within the effective length, which is the register capped
	// at the memory depth
	assign in_range = (CW'(pos_q) < CW'(string_length_q)) &&
	                  (CW'(pos_q) < CW'(MAX_LENGTH));
	assign not_sat  = (CW'(pos_q) < CW'(MAX_LENGTH));

	// Comparison against the stored row
	assign known    = (row_rd[ROW_W-1 -: SYMBOL_W] == sym_q) || row_rd[sym_q];
	assign cnt_next = (in_range && op_q == OP_QUERY && !known && cnt_q < DIST_MAX)
	                  ? cnt_q + DIST_W'(1) : cnt_q;

	// Updated row for an insert: base byte on the first string, seen bit after
	always_comb begin
		row_wr = row_rd;
		if (started_q) begin
			row_wr[sym_q] = 1'b1;
		end else begin
			row_wr[ROW_W-1 -: SYMBOL_W] = sym_q;
		end
	end

	// Memory write port: zero rows during the clearing sweep, else updates
	always_comb begin
		if (cmd.clear_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = cmd.exec && in_range && op_q == OP_INSERT;
			ram_waddr = pos_q[AW-1:0];
			ram_wdata = row_wr;
		end
	end

	pssd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_LENGTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (cmd.accept),
		.rd_addr (pos_q[AW-1:0]),
		.rd_data (row_rd)
	);

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Position, count and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else if (cmd.exec) begin
			if (last_q) begin
				pos_q <= '0;
				cnt_q <= '0;
				if (op_q == OP_INSERT) begin
					started_q <= 1'b1;
				end
			end else begin
				cnt_q <= cnt_next;
				if (not_sat) begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.exec && last_q && op_q == OP_QUERY) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && last_q && op_q == OP_QUERY) begin
			dist_q <= cnt_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, dist_q};

	// Status to the controller
	always_comb begin
		sts.clear_last  = (clr_q == AW'(MAX_LENGTH - 1));
		sts.need_out    = last_q && op_q == OP_QUERY;
		sts.out_blocked = m_tvalid_q && !m_tready;
	end

endmodule

/* hw/rtl/positional_symbol_set_distance_unit.sv */
// ----------------------------------------------------------------------------
// positional_symbol_set_distance_unit
// Keeps a per-position profile of byte strings and reports, for a query
// string, how many positions hold a byte outside that profile.
// ----------------------------------------------------------------------------
// Usage:
//   Strings arrive on the slave stream one byte per transaction: s_tdata is
//   the byte, s_tuser selects insert (0) or query (1), s_tlast marks the
//   final byte. The first inserted string sets the base bytes; later ones
//   record each byte in the seen set of its position. A query string yields
//   one transaction on the master stream on its last byte, carrying the
//   count of positions whose byte was neither base nor seen.
//   The cfg channel writes the compared string length; write it only while
//   the block is idle. cfg_ready is always high.
// Byte handling:
//   For each byte, its position's profile row is read from the
//   single-port-per-direction profile memory and then updated; a new byte
//   is not taken until that update is done. A query result is registered
//   in the output register when the update of its last byte is done.
// Reset and stalls:
//   After reset a clearing sweep zeroes every row of the profile memory;
//   s_tready stays low meanwhile. One finished result is held in an
//   output register while further bytes are accepted; a second query result
//   waits until the receiver takes the first one.
// ----------------------------------------------------------------------------
module positional_symbol_set_distance_unit #(
	parameter int unsigned MAX_LENGTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tuser,   // [0] op
	input  logic       s_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data,  // [6:0] string_length
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [6:0] distance, [7] zero
);

	import pssd_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	pssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pssd_dp #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
